// ----- rtl/mslc_pkg.sv -----
// ----------------------------------------------------------------------------
// Midpoint subdivision line clipper: shared definitions
// Types and codes used by the clipper sequencer and its outcode unit.
// ----------------------------------------------------------------------------
package mslc_pkg;

  // Outcode bit positions (left, right, bottom, top).
  localparam int CODE_BITS   = 4;
  localparam int CODE_LEFT   = 0;
  localparam int CODE_RIGHT  = 1;
  localparam int CODE_BOTTOM = 2;
  localparam int CODE_TOP    = 3;

  typedef logic [CODE_BITS-1:0] code_t;

  localparam code_t CODE_INSIDE = '0;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_WINDOW_LEFT   = 2'd0;
  localparam cfg_index_t REG_WINDOW_RIGHT  = 2'd1;
  localparam cfg_index_t REG_WINDOW_BOTTOM = 2'd2;
  localparam cfg_index_t REG_WINDOW_TOP    = 2'd3;

  // At most this many endpoint moves per segment.
  localparam int OUTER_CAP = 4;
  localparam int PASS_BITS = 3;

  typedef logic [PASS_BITS-1:0] pass_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CODE_A,
    S_CODE_B,
    S_CHECK,
    S_MID,
    S_EVAL,
    S_RECODE,
    S_FINISH
  } state_t;

  // Operand select of the shared outcode unit.
  typedef enum logic [1:0] {
    CSEL_A,
    CSEL_B,
    CSEL_MID
  } code_sel_t;

endpackage

// ----- rtl/mslc_ifs.sv -----
// ----------------------------------------------------------------------------
// Midpoint subdivision line clipper: channel interfaces
// Segment input, clip result and configuration write channels.
// ----------------------------------------------------------------------------

// Segment channel: two endpoints.
interface mslc_seg_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// Result channel: visible flag and clipped endpoints.
interface mslc_res_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic signed [COORD_BITS-1:0] clip_start_x;
  logic signed [COORD_BITS-1:0] clip_start_y;
  logic signed [COORD_BITS-1:0] clip_end_x;
  logic signed [COORD_BITS-1:0] clip_end_y;

  modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, input ready);
  modport sink   (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, output ready);
endinterface

// Configuration write channel.
interface mslc_cfg_if
  import mslc_pkg::*;
#(
  parameter int COORD_BITS = 24
);
  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [COORD_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/midpoint_subdivision_line_clip.sv -----
// ----------------------------------------------------------------------------
// Midpoint subdivision line clipper
// Clips one segment against a rectangular window by repeated bisection.
// ----------------------------------------------------------------------------
// One segment is handled at a time; segment.ready is high only while the
// block is idle. After the item is taken, the two endpoint outcodes are found
// one after the other and a check state follows. Each move of an outside
// endpoint repeats halving steps (midpoint add, then classify and update),
// then recodes the moved endpoint and checks again; there are at most four
// moves per segment. The finish state loads the result register once the
// output is free. The design has one midpoint adder pair and one outcode
// unit. The result register lets a new segment be taken while the previous
// result still waits. Window registers are written through the cfg channel,
// which is always ready; write them only while idle.
// ----------------------------------------------------------------------------
module midpoint_subdivision_line_clip
  import mslc_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  mslc_seg_if.sink     segment,
  mslc_res_if.source   result,
  mslc_cfg_if.sink     cfg
);

  state_t state;
  state_t state_next;

  logic signed [COORD_BITS-1:0] window_left;
  logic signed [COORD_BITS-1:0] window_right;
  logic signed [COORD_BITS-1:0] window_bottom;
  logic signed [COORD_BITS-1:0] window_top;

  // Endpoint a is also the near bound during bisection.
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic signed [COORD_BITS-1:0] far_x;
  logic signed [COORD_BITS-1:0] far_y;
  logic signed [COORD_BITS-1:0] mid_x;
  logic signed [COORD_BITS-1:0] mid_y;
  code_t                        ca;
  code_t                        cb;
  pass_t                        pass;

  code_sel_t                    code_sel;
  logic signed [COORD_BITS-1:0] code_x;
  logic signed [COORD_BITS-1:0] code_y;
  code_t                        code;

  logic [COORD_BITS:0]          sum_x;
  logic [COORD_BITS:0]          sum_y;
  logic                         both_inside;
  logic                         reject;
  logic                         bisect_done;
  logic                         out_free;

  // Configuration writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left   <= '0;
      window_right  <= '0;
      window_bottom <= '0;
      window_top    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WINDOW_LEFT:   window_left   <= cfg.data;
        REG_WINDOW_RIGHT:  window_right  <= cfg.data;
        REG_WINDOW_BOTTOM: window_bottom <= cfg.data;
        REG_WINDOW_TOP:    window_top    <= cfg.data;
        default:           ;
      endcase
    end
  end

  // Shared outcode unit and its operand select.
  always_comb begin
    unique case (code_sel)
      CSEL_A: begin
        code_x = ax;
        code_y = ay;
      end
      CSEL_B: begin
        code_x = bx;
        code_y = by;
      end
      CSEL_MID: begin
        code_x = mid_x;
        code_y = mid_y;
      end
      default: begin
        code_x = ax;
        code_y = ay;
      end
    endcase
  end

  mslc_outcode #(
    .COORD_BITS (COORD_BITS)
  ) u_outcode (
    .x             (code_x),
    .y             (code_y),
    .window_left   (window_left),
    .window_right  (window_right),
    .window_bottom (window_bottom),
    .window_top    (window_top),
    .code          (code)
  );

  // Floor of half the sum: sign-extended add, then drop the low bit.
  assign sum_x = {ax[COORD_BITS-1], ax} + {far_x[COORD_BITS-1], far_x};
  assign sum_y = {ay[COORD_BITS-1], ay} + {far_y[COORD_BITS-1], far_y};

  // Decisions of the check and evaluate steps.
  assign both_inside = (ca == CODE_INSIDE) && (cb == CODE_INSIDE);
  assign reject      = (pass == PASS_BITS'(OUTER_CAP)) || ((ca & cb) != CODE_INSIDE);
  assign bisect_done = ((mid_x == ax) && (mid_y == ay)) ||
                       ((mid_x == far_x) && (mid_y == far_y));
  assign out_free    = !result.valid || result.ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (segment.valid) state_next = S_CODE_A;
      S_CODE_A: state_next = S_CODE_B;
      S_CODE_B: state_next = S_CHECK;
      S_CHECK: begin
        if (both_inside || reject) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_MID;
        end
      end
      S_MID:    state_next = S_EVAL;
      S_EVAL: begin
        if (bisect_done) begin
          state_next = S_RECODE;
        end else begin
          state_next = S_MID;
        end
      end
      S_RECODE: state_next = S_CHECK;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    segment.ready = 1'b0;
    code_sel      = CSEL_A;
    unique case (state)
      S_IDLE:   segment.ready = 1'b1;
      S_CODE_B: code_sel = CSEL_B;
      S_EVAL:   code_sel = CSEL_MID;
      default:  code_sel = CSEL_A;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Endpoint, bound and midpoint datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (segment.valid) begin
          ax   <= segment.start_x;
          ay   <= segment.start_y;
          bx   <= segment.end_x;
          by   <= segment.end_y;
          pass <= '0;
        end
      end
      S_CODE_A, S_RECODE: ca <= code;
      S_CODE_B:           cb <= code;
      S_CHECK: begin
        // Put the outside endpoint first; the other one is the far bound.
        if (!both_inside && !reject) begin
          pass <= pass + PASS_BITS'(1);
          if (ca == CODE_INSIDE) begin
            ax    <= bx;
            ay    <= by;
            bx    <= ax;
            by    <= ay;
            ca    <= cb;
            cb    <= ca;
            far_x <= ax;
            far_y <= ay;
          end else begin
            far_x <= bx;
            far_y <= by;
          end
        end
      end
      S_MID: begin
        mid_x <= sum_x[COORD_BITS:1];
        mid_y <= sum_y[COORD_BITS:1];
      end
      S_EVAL: begin
        // An inside midpoint becomes the far bound, an outside one the near.
        if (bisect_done) begin
          if (code == CODE_INSIDE) begin
            ax <= mid_x;
            ay <= mid_y;
          end else begin
            ax <= far_x;
            ay <= far_y;
          end
        end else if (code == CODE_INSIDE) begin
          far_x <= mid_x;
          far_y <= mid_y;
        end else begin
          ax <= mid_x;
          ay <= mid_y;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      result.visible <= both_inside;
      if (both_inside) begin
        result.clip_start_x <= ax;
        result.clip_start_y <= ay;
        result.clip_end_x   <= bx;
        result.clip_end_y   <= by;
      end else begin
        result.clip_start_x <= '0;
        result.clip_start_y <= '0;
        result.clip_end_x   <= '0;
        result.clip_end_y   <= '0;
      end
    end
  end

endmodule

// ----- rtl/mslc_outcode.sv -----
// ----------------------------------------------------------------------------
// Midpoint subdivision line clipper: outcode unit
// Classifies one point against the clip window with four signed compares.
// ----------------------------------------------------------------------------
module mslc_outcode
  import mslc_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  input  logic signed [COORD_BITS-1:0] window_left,
  input  logic signed [COORD_BITS-1:0] window_right,
  input  logic signed [COORD_BITS-1:0] window_bottom,
  input  logic signed [COORD_BITS-1:0] window_top,
  output code_t                        code
);

  logic is_left;
  logic is_bottom;

  // Right is tested only when not left, top only when not bottom.
  always_comb begin
    is_left                = x < window_left;
    is_bottom              = y < window_bottom;
    code                   = CODE_INSIDE;
    code[CODE_LEFT]        = is_left;
    code[CODE_RIGHT]       = !is_left && (x > window_right);
    code[CODE_BOTTOM]      = is_bottom;
    code[CODE_TOP]         = !is_bottom && (y > window_top);
  end

endmodule

// ----- tb/midpoint_subdivision_line_clip_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint subdivision line clipper: testbench
// Sends segments through the clipper under several window settings and checks
// each clip result against a typed result or an in-bench model of the
// bisection. A short table of directed segments comes first, then random
// segments in eight window phases. Both channels pause at random, and a
// watchdog ends a stuck run.
module midpoint_subdivision_line_clip_tb;
  import mslc_pkg::*;

  localparam int COORD_BITS = 24;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));
  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam int MIDPOINT_STEP_CAP = 64;
  localparam int RANDOM_PHASES = 8;
  localparam int SEGMENTS_PER_PHASE = 225;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_TAIL = 250;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } segment_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } clip_t;

  // A directed row either sets the window or sends one segment; a segment row
  // says whether its result is typed in or left to the model below.
  typedef enum {
    ROW_WINDOW,
    ROW_PREDICT,
    ROW_KEPT,
    ROW_REJECTED
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    coord_t    a;
    coord_t    b;
    coord_t    c;
    coord_t    d;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  mslc_seg_if #(.COORD_BITS(COORD_BITS)) segment_ch ();
  mslc_res_if #(.COORD_BITS(COORD_BITS)) result_ch ();
  mslc_cfg_if #(.COORD_BITS(COORD_BITS)) cfg_ch ();

  midpoint_subdivision_line_clip #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .segment(segment_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Window as the bench believes it is programmed, sign extended.
  longint win_left;
  longint win_right;
  longint win_bottom;
  longint win_top;

  clip_t         pending_clips[$];
  directed_row_t directed_rows[$];
  int            mismatch_count;
  int            result_count;
  int            stall_left;
  int            quiet_cycles;
  bit            source_idling;
  bit            sink_idling;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Clip model
  // ---------------------------------------------------------------------------

  function automatic code_t region_code(longint x, longint y);
    code_t c;
    c = CODE_INSIDE;
    if (x < win_left) begin
      c[CODE_LEFT] = 1'b1;
    end else if (x > win_right) begin
      c[CODE_RIGHT] = 1'b1;
    end
    if (y < win_bottom) begin
      c[CODE_BOTTOM] = 1'b1;
    end else if (y > win_top) begin
      c[CODE_TOP] = 1'b1;
    end
    return c;
  endfunction

  // Move the outside point (nx, ny) toward (fx, fy) by halving the interval.
  // An inside midpoint pulls the far bound in, an outside one the near bound.
  function automatic void bisect_toward(inout longint nx, inout longint ny,
                                        input longint fx, input longint fy);
    longint ax;
    longint ay;
    longint mx;
    longint my;
    code_t  mc;
    ax = nx;
    ay = ny;
    mx = (ax + fx) >>> 1;
    my = (ay + fy) >>> 1;
    mc = region_code(mx, my);
    for (int i = 0; i < MIDPOINT_STEP_CAP; i++) begin
      // Stop once the midpoint no longer moves either bound.
      if (mx == ax && my == ay) break;
      if (mx == fx && my == fy) break;
      if (mc == CODE_INSIDE) begin
        fx = mx;
        fy = my;
      end else begin
        ax = mx;
        ay = my;
      end
      mx = (ax + fx) >>> 1;
      my = (ay + fy) >>> 1;
      mc = region_code(mx, my);
    end
    if (mc == CODE_INSIDE) begin
      nx = mx;
      ny = my;
    end else begin
      nx = fx;
      ny = fy;
    end
  endfunction

  function automatic clip_t clip_segment(segment_t s);
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint tx;
    longint ty;
    code_t  ca;
    code_t  cb;
    code_t  tc;
    bit     keep;
    clip_t  r;
    ax = s.start_x;
    ay = s.start_y;
    bx = s.end_x;
    by = s.end_y;
    ca = region_code(ax, ay);
    cb = region_code(bx, by);
    keep = 1'b1;
    for (int k = 0; k < OUTER_CAP && (ca != CODE_INSIDE || cb != CODE_INSIDE); k++) begin
      if ((ca & cb) != CODE_INSIDE) begin
        keep = 1'b0;
        break;
      end
      // The point being moved must be the outside one.
      if (ca == CODE_INSIDE) begin
        tx = ax;
        ty = ay;
        tc = ca;
        ax = bx;
        ay = by;
        ca = cb;
        bx = tx;
        by = ty;
        cb = tc;
      end
      bisect_toward(ax, ay, bx, by);
      ca = region_code(ax, ay);
    end
    if (ca != CODE_INSIDE || cb != CODE_INSIDE) keep = 1'b0;
    r = '0;
    if (keep) begin
      r.visible      = 1'b1;
      r.clip_start_x = coord_t'(ax);
      r.clip_start_y = coord_t'(ay);
      r.clip_end_x   = coord_t'(bx);
      r.clip_end_y   = coord_t'(by);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Uniform value in [lo, hi] after clamping both ends to the coordinate range.
  function automatic longint rand_between(longint lo, longint hi);
    longint l;
    longint h;
    l = (lo < COORD_MIN) ? COORD_MIN : lo;
    h = (hi > COORD_MAX) ? COORD_MAX : hi;
    if (l > COORD_MAX) l = COORD_MAX;
    if (h < COORD_MIN) h = COORD_MIN;
    if (h <= l) return l;
    return l + longint'($urandom_range(0, int'(h - l)));
  endfunction

  function automatic void add_row(row_kind_t kind, longint a, longint b,
                                  longint c, longint d);
    directed_row_t row;
    row.kind = kind;
    row.a    = coord_t'(a);
    row.b    = coord_t'(b);
    row.c    = coord_t'(c);
    row.d    = coord_t'(d);
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] result %0d: %s", $realtime, result_count, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write one window register; valid is left high for a following write.
  task automatic write_reg(cfg_index_t idx, coord_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_WINDOW_LEFT:   win_left   = value;
      REG_WINDOW_RIGHT:  win_right  = value;
      REG_WINDOW_BOTTOM: win_bottom = value;
      REG_WINDOW_TOP:    win_top    = value;
      default: ;
    endcase
  endtask

  task automatic set_window(longint l, longint r, longint b, longint t);
    write_reg(REG_WINDOW_LEFT, coord_t'(l));
    write_reg(REG_WINDOW_RIGHT, coord_t'(r));
    write_reg(REG_WINDOW_BOTTOM, coord_t'(b));
    write_reg(REG_WINDOW_TOP, coord_t'(t));
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold off new segments until every outstanding clip result is back.
  task automatic wait_for_results();
    segment_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_clips.size() != 0);
  endtask

  // Offer one segment; on acceptance queue the typed result or the model's.
  task automatic send_segment(segment_t s, bit typed, clip_t want);
    int gap;
    gap = source_idling ? pick_gap() : 0;
    if (gap > 0) begin
      segment_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    segment_ch.valid   <= 1'b1;
    segment_ch.start_x <= s.start_x;
    segment_ch.start_y <= s.start_y;
    segment_ch.end_x   <= s.end_x;
    segment_ch.end_y   <= s.end_y;
    do @(posedge clk); while (!segment_ch.ready);
    pending_clips.push_back(typed ? want : clip_segment(s));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      if (sink_idling) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_result
    clip_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_clips.size() == 0) begin
        report_mismatch("clip result with no segment outstanding");
      end else begin
        want = pending_clips.pop_front();
        if (result_ch.visible !== want.visible)
          report_mismatch($sformatf("visible got %b want %b",
                                    result_ch.visible, want.visible));
        if (result_ch.clip_start_x !== want.clip_start_x)
          report_mismatch($sformatf("clip_start_x got %0d want %0d",
                                    result_ch.clip_start_x, want.clip_start_x));
        if (result_ch.clip_start_y !== want.clip_start_y)
          report_mismatch($sformatf("clip_start_y got %0d want %0d",
                                    result_ch.clip_start_y, want.clip_start_y));
        if (result_ch.clip_end_x !== want.clip_end_x)
          report_mismatch($sformatf("clip_end_x got %0d want %0d",
                                    result_ch.clip_end_x, want.clip_end_x));
        if (result_ch.clip_end_y !== want.clip_end_y)
          report_mismatch($sformatf("clip_end_y got %0d want %0d",
                                    result_ch.clip_end_y, want.clip_end_y));
      end
      result_count++;
    end
  end

  // Watchdog: any accepted item on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (segment_ch.valid && segment_ch.ready) ||
        (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item accepted for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_clips.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    segment_t s;
    longint   l;
    longint   r;
    longint   b;
    longint   t;
    longint   lo_x;
    longint   hi_x;
    longint   lo_y;
    longint   hi_y;
    longint   span;
    longint   cx;
    longint   cy;
    int       pick;

    rst                = 1'b1;
    segment_ch.valid   = 1'b0;
    segment_ch.start_x = '0;
    segment_ch.start_y = '0;
    segment_ch.end_x   = '0;
    segment_ch.end_y   = '0;
    result_ch.ready    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_WINDOW_LEFT;
    cfg_ch.data        = '0;
    win_left           = 0;
    win_right          = 0;
    win_bottom         = 0;
    win_top            = 0;
    mismatch_count     = 0;
    result_count       = 0;
    stall_left         = 0;
    quiet_cycles       = 0;
    source_idling      = 1'b1;
    sink_idling        = 1'b1;

    // Directed segments. Window rows give left, right, bottom, top.
    // With the reset window only the origin is inside.
    add_row(ROW_KEPT, 0, 0, 0, 0);
    add_row(ROW_REJECTED, 1, 0, 2, 0);
    add_row(ROW_PREDICT, -256, 256, 256, -256);
    add_row(ROW_WINDOW, -'h1000, 'h1000, -'h800, 'h800);
    // Fully inside, and exactly on the corners.
    add_row(ROW_KEPT, -'h800, -'h400, 'h800, 'h400);
    add_row(ROW_KEPT, -'h1000, -'h800, 'h1000, 'h800);
    // Both ends beyond the same edge.
    add_row(ROW_REJECTED, -'h3000, 0, -'h2000, 'h100);
    add_row(ROW_REJECTED, 0, 'h1000, 'h100, 'h2000);
    add_row(ROW_REJECTED, 0, -'h1000, 'h100, -'h2000);
    add_row(ROW_REJECTED, 'h2000, 0, 'h3000, 0);
    // One end outside, then the inside end given first so the ends swap.
    add_row(ROW_PREDICT, -'h3000, 0, 0, 0);
    add_row(ROW_PREDICT, 0, 0, 'h3000, 'h100);
    // Both ends outside: crossing the window, and passing a corner.
    add_row(ROW_PREDICT, -'h3000, -'h3000, 'h3000, 'h3000);
    add_row(ROW_PREDICT, -'h3000, 0, 0, 'h3000);
    // Coordinate extremes.
    add_row(ROW_REJECTED, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX);
    add_row(ROW_REJECTED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN);
    add_row(ROW_PREDICT, COORD_MIN, 0, COORD_MAX, 0);
    add_row(ROW_PREDICT, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    add_row(ROW_PREDICT, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    // A single point outside the window.
    add_row(ROW_REJECTED, 'h3000, 'h3000, 'h3000, 'h3000);
    // Window covering the whole coordinate range.
    add_row(ROW_WINDOW, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    add_row(ROW_KEPT, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    add_row(ROW_KEPT, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    // Inverted window: no point can be inside.
    add_row(ROW_WINDOW, 'h100, -'h100, 'h100, -'h100);
    add_row(ROW_REJECTED, 0, 0, 0, 0);
    add_row(ROW_PREDICT, -'h1000, 'h1000, 'h1000, -'h1000);
    // Window shrunk to a single point.
    add_row(ROW_WINDOW, 'h80, 'h80, -'h80, -'h80);
    add_row(ROW_PREDICT, 0, 0, 'h100, -'h100);
    add_row(ROW_KEPT, 'h80, -'h80, 'h80, -'h80);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      s = {directed_rows[i].a, directed_rows[i].b, directed_rows[i].c, directed_rows[i].d};
      case (directed_rows[i].kind)
        ROW_WINDOW: begin
          wait_for_results();
          set_window(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                     directed_rows[i].d);
        end
        ROW_KEPT:     send_segment(s, 1'b1, {1'b1, s});
        ROW_REJECTED: send_segment(s, 1'b1, '0);
        default:      send_segment(s, 1'b0, '0);
      endcase
    end

    // Random phases, each under its own window.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      source_idling = (phase % 3 != 2);
      sink_idling   = (phase % 3 != 2);
      case (phase)
        0, 6: begin
          cx = rand_between(-longint'('h10000), longint'('h10000));
          cy = rand_between(-longint'('h10000), longint'('h10000));
          l  = $urandom_range(1, 'h4000);
          b  = $urandom_range(1, 'h4000);
          r  = cx + l;
          t  = cy + b;
          l  = cx - l;
          b  = cy - b;
        end
        1: begin
          lo_x = rand_between(COORD_MIN, COORD_MAX);
          hi_x = rand_between(COORD_MIN, COORD_MAX);
          lo_y = rand_between(COORD_MIN, COORD_MAX);
          hi_y = rand_between(COORD_MIN, COORD_MAX);
          l = (lo_x < hi_x) ? lo_x : hi_x;
          r = (lo_x < hi_x) ? hi_x : lo_x;
          b = (lo_y < hi_y) ? lo_y : hi_y;
          t = (lo_y < hi_y) ? hi_y : lo_y;
        end
        2: begin
          l = rand_between(COORD_MIN, COORD_MAX - 4);
          b = rand_between(COORD_MIN, COORD_MAX - 4);
          r = l + $urandom_range(0, 4);
          t = b + $urandom_range(0, 4);
        end
        3: begin
          // Raw register bits; the window may well come out inverted.
          l = coord_t'($urandom);
          r = coord_t'($urandom);
          b = coord_t'($urandom);
          t = coord_t'($urandom);
        end
        4: begin
          l = COORD_MIN;
          r = COORD_MAX;
          b = COORD_MIN;
          t = COORD_MAX;
        end
        5: begin
          l = COORD_MAX - 'h1000;
          r = COORD_MAX;
          b = COORD_MIN;
          t = COORD_MIN + 'h1000;
        end
        default: begin
          l = rand_between(0, 'h2000);
          r = l - $urandom_range(1, 'h2000);
          b = rand_between(0, 'h2000);
          t = b - $urandom_range(1, 'h2000);
        end
      endcase
      set_window(l, r, b, t);

      lo_x = (win_left < win_right) ? win_left : win_right;
      hi_x = (win_left < win_right) ? win_right : win_left;
      lo_y = (win_bottom < win_top) ? win_bottom : win_top;
      hi_y = (win_bottom < win_top) ? win_top : win_bottom;
      span = ((hi_x - lo_x) > (hi_y - lo_y)) ? (hi_x - lo_x) : (hi_y - lo_y);
      span = span + 64;

      for (int n = 0; n < SEGMENTS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          // Both ends near the window, so most segments need clipping.
          s.start_x = coord_t'(rand_between(lo_x - span, hi_x + span));
          s.start_y = coord_t'(rand_between(lo_y - span, hi_y + span));
          s.end_x   = coord_t'(rand_between(lo_x - span, hi_x + span));
          s.end_y   = coord_t'(rand_between(lo_y - span, hi_y + span));
        end else if (pick < 8) begin
          // One end within the window's coordinate span, the other anywhere.
          s.start_x = coord_t'(rand_between(lo_x, hi_x));
          s.start_y = coord_t'(rand_between(lo_y, hi_y));
          s.end_x   = coord_t'($urandom);
          s.end_y   = coord_t'($urandom);
          if ($urandom_range(0, 1) == 1) s = {s.end_x, s.end_y, s.start_x, s.start_y};
        end else begin
          s = segment_t'({$urandom, $urandom, $urandom});
        end
        send_segment(s, 1'b0, '0);
        if ($urandom_range(0, 199) == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
